// ===== rtl/tpc_pkg.sv =====
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared widths, stage numbers, codes and word types of the triangle
// point-containment block.
// ----------------------------------------------------------------------------
package tpc_pkg;

   localparam int COORD_W  = 16;
   localparam int EDGE_W   = COORD_W + 1;
   localparam int PROD_W   = 2 * EDGE_W;
   localparam int DOT_W    = PROD_W + 2;
   localparam int NRM_W    = PROD_W + 1;
   localparam int HALF_W   = DOT_W / 2;
   localparam int BP_W     = 2 * DOT_W;
   localparam int BD_W     = BP_W + 1;
   localparam int HM_W     = NRM_W + EDGE_W;
   localparam int HS_W     = HM_W + 1;
   localparam int T_W      = HM_W + 2;
   localparam int Q_W      = COORD_W + 2;
   localparam int X_W      = T_W + Q_W;
   localparam int Y_W      = Q_W + 2;
   localparam int REG_W    = 3 * COORD_W;

   // pipeline stage numbers
   localparam int ST_IN    = 0;
   localparam int ST_EDGE  = 1;
   localparam int ST_PROD  = 2;
   localparam int ST_DOT   = 3;
   localparam int ST_PART  = 4;
   localparam int ST_FULL  = 5;
   localparam int ST_DIFF  = 6;
   localparam int ST_FLAG  = 7;
   localparam int ST_DIV0  = 8;
   localparam int ST_LAST  = ST_DIV0 + Q_W;
   localparam int N_STAGE  = ST_LAST + 1;

   localparam logic [1:0] CSR_APEX       = 2'd0;
   localparam logic [1:0] CSR_BASE_LEFT  = 2'd1;
   localparam logic [1:0] CSR_BASE_RIGHT = 2'd2;

   localparam logic [1:0] HS_VALID     = 2'd0;
   localparam logic [1:0] HS_VERTICAL  = 2'd1;
   localparam logic [1:0] HS_SATURATED = 2'd2;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
   } req_word_type;

   typedef struct packed {
      logic                      inside_space;
      logic                      inside_ground;
      logic signed [COORD_W-1:0] plane_height;
      logic [1:0]                height_status;
   } rsp_word_type;

   typedef struct packed {
      logic signed [DOT_W-1:0] d00;
      logic signed [DOT_W-1:0] d01;
      logic signed [DOT_W-1:0] d02;
      logic signed [DOT_W-1:0] d11;
      logic signed [DOT_W-1:0] d12;
   } dots_type;

endpackage

// ===== rtl/tpc_front.sv =====
// ----------------------------------------------------------------------------
// tpc_front
// Input capture, edge vectors, products, dot products and plane normal.
// ----------------------------------------------------------------------------
module tpc_front import tpc_pkg::*; (
   input  logic                     clock,
   input  logic                     en,
   input  req_word_type             req_data,
   input  logic [REG_W-1:0]         vtx_apex,
   input  logic [REG_W-1:0]         vtx_left,
   input  logic [REG_W-1:0]         vtx_right,
   output dots_type                 dots_space_ff,
   output dots_type                 dots_ground_ff,
   output logic signed [NRM_W-1:0]  nx_ff,
   output logic signed [NRM_W-1:0]  ny_ff,
   output logic signed [NRM_W-1:0]  nz_ff,
   output logic signed [EDGE_W-1:0] e2x_ff,
   output logic signed [EDGE_W-1:0] e2z_ff,
   output logic signed [COORD_W-1:0] by_ff
);

   req_word_type pt_ff;

   logic signed [EDGE_W-1:0]  e0_ff [3];
   logic signed [EDGE_W-1:0]  e1_ff [3];
   logic signed [EDGE_W-1:0]  e2_ff [3];
   logic signed [COORD_W-1:0] by1_ff;

   logic signed [PROD_W-1:0]  p00_ff [3];
   logic signed [PROD_W-1:0]  p01_ff [3];
   logic signed [PROD_W-1:0]  p02_ff [3];
   logic signed [PROD_W-1:0]  p11_ff [3];
   logic signed [PROD_W-1:0]  p12_ff [3];
   logic signed [PROD_W-1:0]  cr_ff  [6];
   logic signed [EDGE_W-1:0]  e2x2_ff;
   logic signed [EDGE_W-1:0]  e2z2_ff;
   logic signed [COORD_W-1:0] by2_ff;

   logic signed [COORD_W-1:0] pnt [3];

   assign pnt[0] = pt_ff.point_x;
   assign pnt[1] = pt_ff.point_y;
   assign pnt[2] = pt_ff.point_z;

   always_ff @(posedge clock) begin
      if (en) begin
         pt_ff <= req_data;
         for (int k = 0; k < 3; k++) begin
            e0_ff[k] <= EDGE_W'($signed(vtx_right[k*COORD_W +: COORD_W]))
                      - EDGE_W'($signed(vtx_left[k*COORD_W +: COORD_W]));
            e1_ff[k] <= EDGE_W'($signed(vtx_apex[k*COORD_W +: COORD_W]))
                      - EDGE_W'($signed(vtx_left[k*COORD_W +: COORD_W]));
            e2_ff[k] <= EDGE_W'(pnt[k])
                      - EDGE_W'($signed(vtx_left[k*COORD_W +: COORD_W]));
         end
         by1_ff <= $signed(vtx_left[2*COORD_W-1:COORD_W]);

         for (int k = 0; k < 3; k++) begin
            p00_ff[k] <= PROD_W'(e0_ff[k]) * PROD_W'(e0_ff[k]);
            p01_ff[k] <= PROD_W'(e0_ff[k]) * PROD_W'(e1_ff[k]);
            p02_ff[k] <= PROD_W'(e0_ff[k]) * PROD_W'(e2_ff[k]);
            p11_ff[k] <= PROD_W'(e1_ff[k]) * PROD_W'(e1_ff[k]);
            p12_ff[k] <= PROD_W'(e1_ff[k]) * PROD_W'(e2_ff[k]);
         end
         // cross terms of (C-B) x (A-B)
         cr_ff[0] <= PROD_W'(e0_ff[1]) * PROD_W'(e1_ff[2]);
         cr_ff[1] <= PROD_W'(e0_ff[2]) * PROD_W'(e1_ff[1]);
         cr_ff[2] <= PROD_W'(e0_ff[2]) * PROD_W'(e1_ff[0]);
         cr_ff[3] <= PROD_W'(e0_ff[0]) * PROD_W'(e1_ff[2]);
         cr_ff[4] <= PROD_W'(e0_ff[0]) * PROD_W'(e1_ff[1]);
         cr_ff[5] <= PROD_W'(e0_ff[1]) * PROD_W'(e1_ff[0]);
         e2x2_ff <= e2_ff[0];
         e2z2_ff <= e2_ff[2];
         by2_ff  <= by1_ff;

         dots_space_ff.d00 <= DOT_W'(p00_ff[0]) + DOT_W'(p00_ff[1]) + DOT_W'(p00_ff[2]);
         dots_space_ff.d01 <= DOT_W'(p01_ff[0]) + DOT_W'(p01_ff[1]) + DOT_W'(p01_ff[2]);
         dots_space_ff.d02 <= DOT_W'(p02_ff[0]) + DOT_W'(p02_ff[1]) + DOT_W'(p02_ff[2]);
         dots_space_ff.d11 <= DOT_W'(p11_ff[0]) + DOT_W'(p11_ff[1]) + DOT_W'(p11_ff[2]);
         dots_space_ff.d12 <= DOT_W'(p12_ff[0]) + DOT_W'(p12_ff[1]) + DOT_W'(p12_ff[2]);
         // x-z projection drops the y terms
         dots_ground_ff.d00 <= DOT_W'(p00_ff[0]) + DOT_W'(p00_ff[2]);
         dots_ground_ff.d01 <= DOT_W'(p01_ff[0]) + DOT_W'(p01_ff[2]);
         dots_ground_ff.d02 <= DOT_W'(p02_ff[0]) + DOT_W'(p02_ff[2]);
         dots_ground_ff.d11 <= DOT_W'(p11_ff[0]) + DOT_W'(p11_ff[2]);
         dots_ground_ff.d12 <= DOT_W'(p12_ff[0]) + DOT_W'(p12_ff[2]);
         nx_ff  <= NRM_W'(cr_ff[0]) - NRM_W'(cr_ff[1]);
         ny_ff  <= NRM_W'(cr_ff[2]) - NRM_W'(cr_ff[3]);
         nz_ff  <= NRM_W'(cr_ff[4]) - NRM_W'(cr_ff[5]);
         e2x_ff <= e2x2_ff;
         e2z_ff <= e2z2_ff;
         by_ff  <= by2_ff;
      end
   end

endmodule

// ===== rtl/tpc_bary.sv =====
// ----------------------------------------------------------------------------
// tpc_bary
// Barycentric sign test: split products, determinants, inside flag.
// ----------------------------------------------------------------------------
module tpc_bary import tpc_pkg::*; (
   input  logic     clock,
   input  logic     en,
   input  dots_type dots,
   output logic     inside_ff
);

   logic signed [DOT_W-1:0]          opa [6];
   logic signed [DOT_W-1:0]          opb [6];
   logic signed [DOT_W+HALF_W:0]     plo_ff [6];
   logic signed [2*DOT_W-HALF_W-1:0] phi_ff [6];
   logic signed [BP_W-1:0]           full_ff [6];
   logic signed [BD_W-1:0]           den_ff;
   logic signed [BD_W-1:0]           nu_ff;
   logic signed [BD_W-1:0]           nv_ff;
   logic signed [BD_W+1:0]           rest;

   // den = d00*d11 - d01*d01, nu = d11*d02 - d01*d12, nv = d00*d12 - d01*d02
   assign opa[0] = dots.d00;  assign opb[0] = dots.d11;
   assign opa[1] = dots.d01;  assign opb[1] = dots.d01;
   assign opa[2] = dots.d11;  assign opb[2] = dots.d02;
   assign opa[3] = dots.d01;  assign opb[3] = dots.d12;
   assign opa[4] = dots.d00;  assign opb[4] = dots.d12;
   assign opa[5] = dots.d01;  assign opb[5] = dots.d02;

   assign rest = (BD_W+2)'(den_ff) - (BD_W+2)'(nu_ff) - (BD_W+2)'(nv_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 6; k++) begin
            plo_ff[k] <= (DOT_W+HALF_W+1)'(opa[k])
                       * (DOT_W+HALF_W+1)'($signed({1'b0, opb[k][HALF_W-1:0]}));
            phi_ff[k] <= (2*DOT_W-HALF_W)'(opa[k])
                       * (2*DOT_W-HALF_W)'($signed(opb[k][DOT_W-1:HALF_W]));
            full_ff[k] <= (BP_W'(phi_ff[k]) <<< HALF_W) + BP_W'(plo_ff[k]);
         end
         den_ff <= BD_W'(full_ff[0]) - BD_W'(full_ff[1]);
         nu_ff  <= BD_W'(full_ff[2]) - BD_W'(full_ff[3]);
         nv_ff  <= BD_W'(full_ff[4]) - BD_W'(full_ff[5]);
         // degenerate triangle (den not positive) reads as outside
         inside_ff <= !den_ff[BD_W-1] && (den_ff != '0) && !nu_ff[BD_W-1]
                   && !nv_ff[BD_W-1] && !rest[BD_W+1];
      end
   end

endmodule

// ===== rtl/tpc_height.sv =====
// ----------------------------------------------------------------------------
// tpc_height
// Plane height: numerator, rounding offset, bit-per-stage divider, clamp.
// ----------------------------------------------------------------------------
module tpc_height import tpc_pkg::*; (
   input  logic                      clock,
   input  logic                      en,
   input  logic signed [NRM_W-1:0]   nx,
   input  logic signed [NRM_W-1:0]   ny,
   input  logic signed [NRM_W-1:0]   nz,
   input  logic signed [EDGE_W-1:0]  e2x,
   input  logic signed [EDGE_W-1:0]  e2z,
   input  logic signed [COORD_W-1:0] by,
   output logic signed [COORD_W-1:0] height_ff,
   output logic [1:0]                status_ff
);

   typedef struct packed {
      logic [NRM_W:0]            dv;
      logic                      neg;
      logic                      vert;
      logic                      sat;
      logic signed [COORD_W-1:0] by;
   } side_type;

   localparam logic signed [Y_W-1:0] YMAX = Y_W'((64'sd1 <<< (COORD_W - 1)) - 1);
   localparam logic signed [Y_W-1:0] YMIN = -Y_W'(64'sd1 <<< (COORD_W - 1));

   logic signed [HM_W-1:0]    m1_ff, m2_ff;
   logic signed [NRM_W-1:0]   ny4_ff;
   logic signed [COORD_W-1:0] by4_ff, by5_ff, by6_ff;
   logic signed [HS_W-1:0]    s_ff;
   logic [NRM_W-1:0]          mny_ff;
   logic                      nyneg_ff, vert5_ff, neg6_ff, vert6_ff;
   logic [T_W-1:0]            t_ff;
   logic [NRM_W:0]            dv_ff;
   logic [HS_W-1:0]           smag;
   side_type                  side7_ff;
   logic [T_W-1:0]            rem7_ff;
   side_type                  side_ff [Q_W];
   logic [T_W-1:0]            rem_ff  [Q_W];
   logic [Q_W-1:0]            q_ff    [Q_W];
   logic signed [Y_W-1:0]     ysum;
   side_type                  sl;

   assign smag = s_ff[HS_W-1] ? HS_W'(-s_ff) : HS_W'(s_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         m1_ff  <= HM_W'(nx) * HM_W'(e2x);
         m2_ff  <= HM_W'(nz) * HM_W'(e2z);
         ny4_ff <= ny;
         by4_ff <= by;

         s_ff     <= HS_W'(m1_ff) + HS_W'(m2_ff);
         mny_ff   <= ny4_ff[NRM_W-1] ? NRM_W'(-ny4_ff) : NRM_W'(ny4_ff);
         nyneg_ff <= ny4_ff[NRM_W-1];
         vert5_ff <= (ny4_ff == '0);
         by5_ff   <= by4_ff;

         // rounded |num|/|ny| = floor((2|num| + |ny|) / (2|ny|)); num = -s
         t_ff     <= (T_W'(smag) << 1) + T_W'(mny_ff);
         dv_ff    <= {mny_ff, 1'b0};
         neg6_ff  <= (!s_ff[HS_W-1] && (s_ff != '0)) != nyneg_ff;
         vert6_ff <= vert5_ff;
         by6_ff   <= by5_ff;

         rem7_ff       <= t_ff;
         side7_ff.dv   <= dv_ff;
         side7_ff.neg  <= neg6_ff;
         side7_ff.vert <= vert6_ff;
         side7_ff.sat  <= X_W'(t_ff) >= (X_W'(dv_ff) << Q_W);
         side7_ff.by   <= by6_ff;
      end
   end

   for (genvar j = 0; j < Q_W; j++) begin : g_div
      logic [T_W-1:0] rem_prev;
      logic [Q_W-1:0] q_prev;
      side_type       side_prev;
      logic [X_W-1:0] trial;

      if (j == 0) begin : g_first
         assign rem_prev  = rem7_ff;
         assign q_prev    = '0;
         assign side_prev = side7_ff;
      end else begin : g_next
         assign rem_prev  = rem_ff[j-1];
         assign q_prev    = q_ff[j-1];
         assign side_prev = side_ff[j-1];
      end

      assign trial = X_W'(side_prev.dv) << (Q_W - 1 - j);

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[j] <= side_prev;
            if (X_W'(rem_prev) >= trial) begin
               rem_ff[j] <= T_W'(X_W'(rem_prev) - trial);
               q_ff[j]   <= q_prev | (Q_W'(1) << (Q_W - 1 - j));
            end else begin
               rem_ff[j] <= rem_prev;
               q_ff[j]   <= q_prev;
            end
         end
      end
   end

   assign sl   = side_ff[Q_W-1];
   assign ysum = Y_W'(sl.by) + (sl.neg ? -Y_W'($signed({1'b0, q_ff[Q_W-1]}))
                                       :  Y_W'($signed({1'b0, q_ff[Q_W-1]})));

   always_ff @(posedge clock) begin
      if (en) begin
         if (sl.vert) begin
            height_ff <= '0;
            status_ff <= HS_VERTICAL;
         end else if (sl.sat) begin
            height_ff <= sl.neg ? COORD_W'(YMIN) : COORD_W'(YMAX);
            status_ff <= HS_SATURATED;
         end else if (ysum > YMAX) begin
            height_ff <= COORD_W'(YMAX);
            status_ff <= HS_SATURATED;
         end else if (ysum < YMIN) begin
            height_ff <= COORD_W'(YMIN);
            status_ff <= HS_SATURATED;
         end else begin
            height_ff <= COORD_W'(ysum);
            status_ff <= HS_VALID;
         end
      end
   end

endmodule

// ===== rtl/triangle_point_containment.sv =====
// ----------------------------------------------------------------------------
// triangle_point_containment
// Point-in-triangle tests (3D and x-z projection) and plane height per point.
// ----------------------------------------------------------------------------
// One query word in, one result word out, one word per clock sustained while
// the result is taken. The height divider resolves one quotient bit per
// stage, while the 72-bit barycentric products take two stages each (split
// partial products, then a sum). A one-word skid register sits after the last
// stage: when rsp_ready drops with a word at the last stage, the pipeline
// still advances to move that word into the skid register, and then holds
// until the skid word is taken. Vertices are written through the csr_
// port and must only change while no word is in flight. Coordinates are
// signed Q8.8; the fractional point cancels out, so all math is integer.
// ----------------------------------------------------------------------------
module triangle_point_containment import tpc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_word_type     req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_word_type     rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [REG_W-1:0] csr_wdata
);

   logic [REG_W-1:0] vertex_apex_ff, vertex_left_ff, vertex_right_ff;

   logic [N_STAGE-1:0] valid_ff, valid_in;
   logic               skid_full_ff;
   rsp_word_type       skid_ff;
   logic               en;

   dots_type                  dots_space, dots_ground;
   logic signed [NRM_W-1:0]   nx, ny, nz;
   logic signed [EDGE_W-1:0]  e2x, e2z;
   logic signed [COORD_W-1:0] by;
   logic                      in_space, in_ground;
   logic signed [COORD_W-1:0] height;
   logic [1:0]                status;

   // inside flags ride alongside the divider stages
   logic space_dly_ff  [ST_DIV0:ST_LAST];
   logic ground_dly_ff [ST_DIV0:ST_LAST];

   rsp_word_type last_word;

   // whole pipeline moves together unless the skid word is still waiting
   assign en        = !skid_full_ff;
   assign req_ready = en;

   // vertex registers; unknown index is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_apex_ff  <= '0;
         vertex_left_ff  <= '0;
         vertex_right_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_APEX:       vertex_apex_ff  <= csr_wdata;
            CSR_BASE_LEFT:  vertex_left_ff  <= csr_wdata;
            CSR_BASE_RIGHT: vertex_right_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign valid_in = {valid_ff[N_STAGE-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         skid_full_ff <= 1'b0;
      end else begin
         if (en) begin
            valid_ff <= valid_in;
         end
         if (skid_full_ff) begin
            if (rsp_ready) begin
               skid_full_ff <= 1'b0;
            end
         end else if (valid_ff[ST_LAST] && !rsp_ready) begin
            skid_full_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_full_ff) begin
         skid_ff <= last_word;
      end
   end

   tpc_front u_front (
      .clock          (clock),
      .en             (en),
      .req_data       (req_data),
      .vtx_apex       (vertex_apex_ff),
      .vtx_left       (vertex_left_ff),
      .vtx_right      (vertex_right_ff),
      .dots_space_ff  (dots_space),
      .dots_ground_ff (dots_ground),
      .nx_ff          (nx),
      .ny_ff          (ny),
      .nz_ff          (nz),
      .e2x_ff         (e2x),
      .e2z_ff         (e2z),
      .by_ff          (by)
   );

   tpc_bary u_bary_space (
      .clock     (clock),
      .en        (en),
      .dots      (dots_space),
      .inside_ff (in_space)
   );

   tpc_bary u_bary_ground (
      .clock     (clock),
      .en        (en),
      .dots      (dots_ground),
      .inside_ff (in_ground)
   );

   tpc_height u_height (
      .clock     (clock),
      .en        (en),
      .nx        (nx),
      .ny        (ny),
      .nz        (nz),
      .e2x       (e2x),
      .e2z       (e2z),
      .by        (by),
      .height_ff (height),
      .status_ff (status)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         space_dly_ff[ST_DIV0]  <= in_space;
         ground_dly_ff[ST_DIV0] <= in_ground;
         for (int k = ST_DIV0 + 1; k <= ST_LAST; k++) begin
            space_dly_ff[k]  <= space_dly_ff[k-1];
            ground_dly_ff[k] <= ground_dly_ff[k-1];
         end
      end
   end

   assign last_word.inside_space  = space_dly_ff[ST_LAST];
   assign last_word.inside_ground = ground_dly_ff[ST_LAST];
   assign last_word.plane_height  = height;
   assign last_word.height_status = status;

   assign rsp_valid = skid_full_ff || valid_ff[ST_LAST];
   assign rsp_data  = skid_full_ff ? skid_ff : last_word;

endmodule

// ===== rtl/tpc_checker.sv =====
// ----------------------------------------------------------------------------
// tpc_checker
// Port-level checks on the result channel of the containment block.
// ----------------------------------------------------------------------------
module tpc_checker import tpc_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input req_word_type     req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input rsp_word_type     rsp_data,
   input logic             csr_we,
   input logic [1:0]       csr_index,
   input logic [REG_W-1:0] csr_wdata
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.height_status != 2'd3)
      else $error("undefined height status");

   a_vertical_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.height_status == HS_VERTICAL |->
         rsp_data.plane_height == '0)
      else $error("vertical plane with nonzero height");

   a_sat_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.height_status == HS_SATURATED |->
         rsp_data.plane_height == {1'b0, {(COORD_W-1){1'b1}}} ||
         rsp_data.plane_height == {1'b1, {(COORD_W-1){1'b0}}})
      else $error("saturated height not at a rail");

endmodule

bind triangle_point_containment tpc_checker u_tpc_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for triangle_point_containment: vertex writes between
// phases, directed corner words from a table, then random triangles and
// points checked word by word against a bit-exact predictor of the
// containment flags and the plane height, under varying handshake pressure.
// ----------------------------------------------------------------------------
module testbench;
   import tpc_pkg::*;

   localparam logic [1:0] CSR_UNUSED = 2'd3;   // no register behind this index
   localparam int         DRAIN_CYC  = 40;     // covers the full pipeline plus the skid word

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_word_type     req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_word_type     rsp_data;
   logic             csr_we = 1'b0;
   logic [1:0]       csr_index = '0;
   logic [REG_W-1:0] csr_wdata = '0;

   triangle_point_containment dut (.*);

   always #10 clock = ~clock;

   // shadow copy of the vertex registers
   logic [REG_W-1:0] apex_reg, left_reg, right_reg;

   rsp_word_type expected_words[$];
   int           error_count = 0;
   int           sender_idle_pct = 0;
   int           receiver_stall_pct = 0;
   bit           hold_ask = 0;
   bit           hold_taken = 0;
   int           hold_left = 0;

   typedef struct {
      bit               is_cfg;
      logic [1:0]       index;
      logic [REG_W-1:0] wdata;
      req_word_type     point;
      bit               typed;
      rsp_word_type     result;
   } stim_row_type;

   stim_row_type stim_rows[$];

   function automatic longint coord_of(logic [REG_W-1:0] r, int k);
      logic [COORD_W-1:0] c;
      c = r[k*COORD_W +: COORD_W];
      return longint'($signed(c));
   endfunction

   function automatic logic [REG_W-1:0] pack_vertex(longint x, longint y, longint z);
      logic [COORD_W-1:0] px, py, pz;
      px = x[COORD_W-1:0];
      py = y[COORD_W-1:0];
      pz = z[COORD_W-1:0];
      return {pz, py, px};
   endfunction

   // division-free barycentric test relative to the base-left vertex
   function automatic bit bary_inside(longint e0x, longint e0y, longint e0z,
                                      longint e1x, longint e1y, longint e1z,
                                      longint e2x, longint e2y, longint e2z);
      logic signed [127:0] d00, d01, d02, d11, d12, den, nu, nv;
      d00 = e0x*e0x + e0y*e0y + e0z*e0z;
      d01 = e0x*e1x + e0y*e1y + e0z*e1z;
      d02 = e0x*e2x + e0y*e2y + e0z*e2z;
      d11 = e1x*e1x + e1y*e1y + e1z*e1z;
      d12 = e1x*e2x + e1y*e2y + e1z*e2z;
      den = d00*d11 - d01*d01;
      nu  = d11*d02 - d01*d12;
      nv  = d00*d12 - d01*d02;
      if (den <= 0) return 1'b0;
      if (nu < 0 || nv < 0) return 1'b0;
      return (den - nu - nv) >= 0;
   endfunction

   function automatic rsp_word_type predict_containment(req_word_type p);
      rsp_word_type        r;
      longint              bx, by, bz, e0x, e0y, e0z, e1x, e1y, e1z, e2x, e2y, e2z;
      longint              nx, ny, nz, y, mny;
      logic signed [127:0] num, mag;
      logic [127:0]        q;
      bit                  neg;
      bx  = coord_of(left_reg, 0);
      by  = coord_of(left_reg, 1);
      bz  = coord_of(left_reg, 2);
      e0x = coord_of(right_reg, 0) - bx;
      e0y = coord_of(right_reg, 1) - by;
      e0z = coord_of(right_reg, 2) - bz;
      e1x = coord_of(apex_reg, 0) - bx;
      e1y = coord_of(apex_reg, 1) - by;
      e1z = coord_of(apex_reg, 2) - bz;
      e2x = longint'(p.point_x) - bx;
      e2y = longint'(p.point_y) - by;
      e2z = longint'(p.point_z) - bz;
      nx  = e0y*e1z - e0z*e1y;
      ny  = e0z*e1x - e0x*e1z;
      nz  = e0x*e1y - e0y*e1x;
      r.inside_space  = bary_inside(e0x, e0y, e0z, e1x, e1y, e1z, e2x, e2y, e2z);
      r.inside_ground = bary_inside(e0x, 0, e0z, e1x, 0, e1z, e2x, 0, e2z);
      r.plane_height  = '0;
      r.height_status = HS_VALID;
      if (ny == 0) begin
         r.height_status = HS_VERTICAL;
      end else begin
         num = 128'sd0 - (128'(signed'(nx)) * 128'(signed'(e2x))
                          + 128'(signed'(nz)) * 128'(signed'(e2z)));
         neg = (num < 0) != (ny < 0);
         mag = (num < 0) ? -num : num;
         mny = (ny < 0) ? -ny : ny;
         // round to nearest, ties away from zero
         q = (128'(mag) * 2 + 128'(mny)) / (128'(mny) * 2);
         if (q > (128'd1 << 40)) begin
            r.plane_height  = neg ? 16'sh8000 : 16'sh7fff;
            r.height_status = HS_SATURATED;
         end else begin
            y = neg ? by - longint'(q[63:0]) : by + longint'(q[63:0]);
            if (y > 32767) begin
               y = 32767;
               r.height_status = HS_SATURATED;
            end else if (y < -32768) begin
               y = -32768;
               r.height_status = HS_SATURATED;
            end
            r.plane_height = y[COORD_W-1:0];
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   // result checker: in-order compare against the oldest expectation
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            report_mismatch("unexpected word", rsp_data, 0);
         end else begin
            want = expected_words.pop_front();
            if (rsp_data.inside_space !== want.inside_space)
               report_mismatch("inside_space", rsp_data.inside_space, want.inside_space);
            if (rsp_data.inside_ground !== want.inside_ground)
               report_mismatch("inside_ground", rsp_data.inside_ground, want.inside_ground);
            if (rsp_data.plane_height !== want.plane_height)
               report_mismatch("plane_height", rsp_data.plane_height, want.plane_height);
            if (rsp_data.height_status !== want.height_status)
               report_mismatch("height_status", rsp_data.height_status, want.height_status);
         end
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_ask && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= 300;
         rsp_ready  <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   task automatic send_point(req_word_type p, rsp_word_type want);
      req_valid <= 1'b1;
      req_data  <= p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_words.push_back(want);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < sender_idle_pct) @(posedge clock);
      end
   endtask

   // vertices may only change with nothing in flight
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [REG_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_APEX:       apex_reg  = value;
         CSR_BASE_LEFT:  left_reg  = value;
         CSR_BASE_RIGHT: right_reg = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_triangle(logic [REG_W-1:0] a, logic [REG_W-1:0] b,
                               logic [REG_W-1:0] c);
      wait_idle();
      write_reg(CSR_APEX, a);
      write_reg(CSR_BASE_LEFT, b);
      write_reg(CSR_BASE_RIGHT, c);
   endtask

   task automatic add_cfg(logic [1:0] idx, logic [REG_W-1:0] value);
      stim_row_type row;
      row = '{default: '0};
      row.is_cfg = 1'b1;
      row.index  = idx;
      row.wdata  = value;
      stim_rows.push_back(row);
   endtask

   task automatic add_point(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                            bit typed, rsp_word_type want);
      stim_row_type row;
      row = '{default: '0};
      row.point  = '{point_x: x, point_y: y, point_z: z};
      row.typed  = typed;
      row.result = want;
      stim_rows.push_back(row);
   endtask

   function automatic longint rand_coord(int span);
      if (span >= 32767) return longint'($signed(16'($urandom)));
      return longint'($urandom_range(2*span)) - span;
   endfunction

   // random points: mostly near the triangle, some anywhere
   task automatic random_phase(int count);
      req_word_type p;
      longint       bx, by, bz, s, t;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 70) begin
            bx = coord_of(left_reg, 0);
            by = coord_of(left_reg, 1);
            bz = coord_of(left_reg, 2);
            s  = $urandom_range(320);
            t  = $urandom_range(320);
            bx = bx + (s*(coord_of(right_reg, 0) - bx) + t*(coord_of(apex_reg, 0) - bx)) / 256;
            bz = bz + (s*(coord_of(right_reg, 2) - bz) + t*(coord_of(apex_reg, 2) - bz)) / 256;
            by = by + (s*(coord_of(right_reg, 1) - by) + t*(coord_of(apex_reg, 1) - by)) / 256
                    + longint'($urandom_range(64)) - 32;
            p.point_x = bx[15:0];
            p.point_y = by[15:0];
            p.point_z = bz[15:0];
         end else begin
            p = req_word_type'($urandom);
            p.point_x = 16'($urandom);
         end
         send_point(p, predict_containment(p));
      end
   endtask

   initial begin
      rsp_word_type want;
      longint       ax, az, bx, bz;
      int           k;
      apex_reg  = '0;
      left_reg  = '0;
      right_reg = '0;

      // --- directed table ---
      // all vertices zero: vertical plane, degenerate
      want = '{inside_space: 0, inside_ground: 0, plane_height: 0, height_status: HS_VERTICAL};
      add_point(16'h0000, 16'h0000, 16'h0000, 1, want);
      add_point(16'h7fff, 16'h7fff, 16'h7fff, 1, want);
      add_point(16'h8000, 16'h8000, 16'h8000, 1, want);
      // flat unit triangle in y = 0
      add_cfg(CSR_APEX,       pack_vertex(0, 0, 256));
      add_cfg(CSR_BASE_LEFT,  pack_vertex(0, 0, 0));
      add_cfg(CSR_BASE_RIGHT, pack_vertex(256, 0, 0));
      want = '{inside_space: 1, inside_ground: 1, plane_height: 0, height_status: HS_VALID};
      add_point(16'd64, 16'd0, 16'd64, 1, want);
      add_point(16'd64, 16'd1000, 16'd64, 1, want);   // off-plane y ignored
      add_point(16'd0, 16'd0, 16'd0, 1, want);        // on a vertex
      want = '{inside_space: 0, inside_ground: 0, plane_height: 0, height_status: HS_VALID};
      add_point(16'hffff, 16'd0, 16'd0, 1, want);
      add_point(16'h7fff, 16'h7fff, 16'h7fff, 1, want);
      add_point(16'h8000, 16'h8000, 16'h8000, 1, want);
      add_point(16'd128, 16'd0, 16'd128, 0, want);    // on the hypotenuse
      // write to an unused index changes nothing
      add_cfg(CSR_UNUSED, 48'hffff_ffff_ffff);
      add_point(16'd10, 16'd5, 16'd20, 0, want);
      // steep plane: height saturates both ways
      add_cfg(CSR_APEX,       pack_vertex(0, 32767, 1));
      add_cfg(CSR_BASE_RIGHT, pack_vertex(1, 0, 0));
      add_point(16'd0, 16'd0, 16'd100, 0, want);
      add_point(16'd0, 16'd0, 16'hff00, 0, want);
      add_point(16'h7fff, 16'h8000, 16'h7fff, 0, want);
      // collinear vertices: degenerate and vertical
      add_cfg(CSR_APEX,       pack_vertex(4, 0, 4));
      add_cfg(CSR_BASE_RIGHT, pack_vertex(2, 0, 2));
      add_point(16'd2, 16'd0, 16'd2, 0, want);
      // extreme vertices
      add_cfg(CSR_APEX,       48'h7fff_7fff_7fff);
      add_cfg(CSR_BASE_LEFT,  48'h8000_8000_8000);
      add_cfg(CSR_BASE_RIGHT, 48'h8000_7fff_7fff);
      add_point(16'd0, 16'd0, 16'd0, 0, want);
      add_point(16'h8000, 16'h7fff, 16'h8000, 0, want);
      add_point(16'h7fff, 16'h8000, 16'h7fff, 0, want);
      add_point(16'h1234, 16'hedcb, 16'h5555, 0, want);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim_rows[i]) begin
         if (stim_rows[i].is_cfg) begin
            wait_idle();
            write_reg(stim_rows[i].index, stim_rows[i].wdata);
         end else begin
            send_point(stim_rows[i].point, stim_rows[i].typed ? stim_rows[i].result
                       : predict_containment(stim_rows[i].point));
         end
      end

      // --- random phases: triangle sizes and idling patterns vary ---
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 85; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 85; end
            default: begin sender_idle_pct = 16; receiver_stall_pct = 16; end
         endcase
         k = (ph == 0) ? 8 : (ph == 1) ? 64 : (ph == 2) ? 1024 :
             (ph == 3) ? 32767 : (ph == 4) ? 300 : 4000;
         if (ph == 6) begin
            // vertical plane: x-z projection collinear
            bx = rand_coord(500);
            bz = rand_coord(500);
            ax = rand_coord(40);
            az = rand_coord(40);
            set_triangle(pack_vertex(bx + ax, rand_coord(500), bz + az),
                         pack_vertex(bx, rand_coord(500), bz),
                         pack_vertex(bx + 2*ax, rand_coord(500), bz + 2*az));
         end else begin
            set_triangle(pack_vertex(rand_coord(k), rand_coord(k), rand_coord(k)),
                         pack_vertex(rand_coord(k), rand_coord(k), rand_coord(k)),
                         pack_vertex(rand_coord(k), rand_coord(k), rand_coord(k)));
         end
         // long receiver hold-off while points keep coming: fills the pipe
         if (ph == 0) hold_ask = 1;
         random_phase(225);
      end

      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #20ms;
      $display("status: fail");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/tpc_pkg.sv
rtl/tpc_front.sv
rtl/tpc_bary.sv
rtl/tpc_height.sv
rtl/triangle_point_containment.sv
rtl/tpc_checker.sv
tb/testbench.sv
